>>> src/format_specifier_checker_defines.svh
// Assertion macros for the format specifier checker.
// Each macro expects clk and arst_n in scope.
`ifndef FORMAT_SPECIFIER_CHECKER_DEFINES_SVH
`define FORMAT_SPECIFIER_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FSC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define FSC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FSC_ASSERT_NOW(label, ante, cons, msg)
`define FSC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/fsc_pkg.sv
`timescale 1ns / 1ps

package fsc_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PCT,
		PH_FLAGS,
		PH_WIDTH,
		PH_DOT,
		PH_PREC,
		PH_MODS
	} phase_t;

	localparam logic [7:0] CH_PCT  = 8'h25; // '%'
	localparam logic [7:0] CH_STAR = 8'h2A; // '*'
	localparam logic [7:0] CH_DOT  = 8'h2E; // '.'
	localparam logic [7:0] CH_N    = 8'h6E; // 'n'

	localparam logic [7:0] CAPACITY_RESET = 8'd128;

	typedef struct packed {
		logic       has_token;
		logic [7:0] mod_first;
		logic [7:0] mod_second;
		logic [7:0] conversion_char;
		logic [7:0] bytes_used;
		logic       is_final;
		logic       verdict_ok;
	} res_t;

	function automatic logic is_flag(input logic [7:0] c);
		return c inside {8'h2D, 8'h2B, 8'h20, 8'h30, 8'h23}; // - + space 0 #
	endfunction

	function automatic logic is_mod(input logic [7:0] c);
		return c inside {8'h68, 8'h6C, 8'h6A, 8'h7A, 8'h74, 8'h4C}; // h l j z t L
	endfunction

	// d i o u x X e E f F g G a A c s
	function automatic logic is_conv(input logic [7:0] c);
		return c inside {8'h64, 8'h69, 8'h6F, 8'h75, 8'h78, 8'h58, 8'h65, 8'h45,
			8'h66, 8'h46, 8'h67, 8'h47, 8'h61, 8'h41, 8'h63, 8'h73};
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

endpackage

>>> src/fsc_step.sv
`timescale 1ns / 1ps

// Next-state and result logic for one character or terminator.
module fsc_step #(
	parameter int MAX_MODIFIERS = 2,
	localparam int CW = $clog2(MAX_MODIFIERS + 1)
) (
	input  logic [7:0]        char_in,
	input  logic              is_end,
	input  logic [7:0]        capacity,
	input  fsc_pkg::phase_t   phase,
	input  logic [7:0]        mods [MAX_MODIFIERS],
	input  logic [CW-1:0]     mod_count,
	input  logic [7:0]        used,
	input  logic              err,
	output fsc_pkg::phase_t   phase_d,
	output logic [7:0]        mods_d [MAX_MODIFIERS],
	output logic [CW-1:0]     mod_count_d,
	output logic [7:0]        used_d,
	output logic              err_d,
	output logic              emit,
	output fsc_pkg::res_t     res
);

	logic       do_width;
	logic       do_prec;
	logic       do_mc;
	logic [8:0] sum;

	assign sum = {1'b0, used} + 9'(mod_count) + 9'd2;

	always_comb begin
		phase_d     = phase;
		mods_d      = mods;
		mod_count_d = mod_count;
		used_d      = used;
		err_d       = err;
		emit        = 1'b0;
		res         = '0;
		do_width    = 1'b0;
		do_prec     = 1'b0;
		do_mc       = 1'b0;

		if (is_end) begin
			emit           = 1'b1;
			res.is_final   = 1'b1;
			res.bytes_used = used;
			res.verdict_ok = !err && (phase == fsc_pkg::PH_IDLE);
			phase_d        = fsc_pkg::PH_IDLE;
			for (int i = 0; i < MAX_MODIFIERS; i++) mods_d[i] = '0;
			mod_count_d    = '0;
			used_d         = '0;
			err_d          = 1'b0;
		end else if (!err) begin
			case (phase)
				fsc_pkg::PH_IDLE: begin
					if (char_in == fsc_pkg::CH_PCT) phase_d = fsc_pkg::PH_PCT;
				end
				fsc_pkg::PH_PCT, fsc_pkg::PH_FLAGS: begin
					if (phase == fsc_pkg::PH_PCT && char_in == fsc_pkg::CH_PCT) begin
						phase_d = fsc_pkg::PH_IDLE;
					end else if (fsc_pkg::is_flag(char_in)) begin
						phase_d = fsc_pkg::PH_FLAGS;
					end else if (char_in == fsc_pkg::CH_STAR) begin
						err_d   = 1'b1;
						phase_d = fsc_pkg::PH_IDLE;
					end else begin
						do_width = 1'b1;
					end
				end
				fsc_pkg::PH_WIDTH: do_width = 1'b1;
				fsc_pkg::PH_DOT: begin
					if (char_in == fsc_pkg::CH_STAR) begin
						err_d   = 1'b1;
						phase_d = fsc_pkg::PH_IDLE;
					end else begin
						do_prec = 1'b1;
					end
				end
				fsc_pkg::PH_PREC: do_prec = 1'b1;
				fsc_pkg::PH_MODS: do_mc = 1'b1;
				default: phase_d = fsc_pkg::PH_IDLE;
			endcase

			if (do_width) begin
				if (fsc_pkg::is_digit(char_in)) phase_d = fsc_pkg::PH_WIDTH;
				else if (char_in == fsc_pkg::CH_DOT) phase_d = fsc_pkg::PH_DOT;
				else do_mc = 1'b1;
			end
			if (do_prec) begin
				if (fsc_pkg::is_digit(char_in)) phase_d = fsc_pkg::PH_PREC;
				else do_mc = 1'b1;
			end

			if (do_mc) begin
				if (mod_count < CW'(MAX_MODIFIERS) && fsc_pkg::is_mod(char_in)) begin
					for (int i = 0; i < MAX_MODIFIERS; i++)
						if (CW'(i) == mod_count) mods_d[i] = char_in;
					mod_count_d = mod_count + CW'(1);
					phase_d     = fsc_pkg::PH_MODS;
				end else if (char_in == fsc_pkg::CH_N || !fsc_pkg::is_conv(char_in)
						|| sum >= {1'b0, capacity}) begin
					err_d   = 1'b1;
					phase_d = fsc_pkg::PH_IDLE;
				end else begin
					emit                = 1'b1;
					res.has_token       = 1'b1;
					res.conversion_char = char_in;
					res.bytes_used      = sum[7:0];
					for (int i = 0; i < MAX_MODIFIERS; i++) begin
						if (i == 0 && mod_count > CW'(0)) res.mod_first = mods[i];
						if (i == 1 && mod_count > CW'(1)) res.mod_second = mods[i];
						mods_d[i] = '0;
					end
					used_d      = sum[7:0];
					mod_count_d = '0;
					phase_d     = fsc_pkg::PH_IDLE;
				end
			end
		end
	end

endmodule

>>> src/format_specifier_checker.sv
`timescale 1ns / 1ps
// Format specifier checker: reads a printf format string as a stream of one
// byte per beat, closed by a terminator beat (s_tuser high), and flags
// strings that are unsafe as a format: %n, '*' width or precision, unknown
// conversion letters, a specifier left open at the terminator, or a running
// signature count that would reach cfg_wdata's capacity (reset 128). Each
// accepted conversion returns a token beat with its length modifiers, its
// letter and the running byte count; the terminator returns one final beat
// with the verdict and clears all string state. Other characters return
// nothing. The block takes one beat per clock while the master side does
// not stall; a beat passes an input register, then the character decode
// and phase update, then the result register. Beats that return nothing keep
// flowing while the result register is empty; once a result waits on a
// stalled master side, the input side takes at most one more beat and then
// holds. Write the capacity only between strings while no beat is in flight.
`include "format_specifier_checker_defines.svh"

module format_specifier_checker #(
	parameter int MAX_MODIFIERS = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: signature capacity
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	input  logic        s_tuser,   // [0] is_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] mod_first, [15:8] mod_second,
	                               // [23:16] conversion_char, [31:24] bytes_used,
	                               // [32] verdict_ok, [39:33] zero
	output logic [1:0]  m_tuser    // [0] has_token, [1] is_final
);

	localparam int CW = $clog2(MAX_MODIFIERS + 1);

	// input register
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              is_end_s1;
	logic              fire_s1;

	// string state
	fsc_pkg::phase_t   phase_q, phase_d;
	logic [7:0]        mods_q [MAX_MODIFIERS];
	logic [7:0]        mods_d [MAX_MODIFIERS];
	logic [CW-1:0]     mod_count_q, mod_count_d;
	logic [7:0]        used_q, used_d;
	logic              err_q, err_d;
	logic [7:0]        capacity_q;

	// result register
	logic              out_valid_q;
	fsc_pkg::res_t     res_q, res_d;
	logic              emit;
	logic              out_free;

	// Advance the decode stage whenever the result register is empty or drains.
	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= fsc_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_wdata;
		end
	end

	// Capture a beat whenever the input register frees up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1   <= s_tdata;
			is_end_s1 <= s_tuser;
		end
	end

	fsc_step #(
		.MAX_MODIFIERS(MAX_MODIFIERS)
	) u_step (
		.char_in     (char_s1),
		.is_end      (is_end_s1),
		.capacity    (capacity_q),
		.phase       (phase_q),
		.mods        (mods_q),
		.mod_count   (mod_count_q),
		.used        (used_q),
		.err         (err_q),
		.phase_d     (phase_d),
		.mods_d      (mods_d),
		.mod_count_d (mod_count_d),
		.used_d      (used_d),
		.err_d       (err_d),
		.emit        (emit),
		.res         (res_d)
	);

	// Commit the string state only when the decode stage fires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fsc_pkg::PH_IDLE;
			mod_count_q <= '0;
			used_q      <= '0;
			err_q       <= 1'b0;
			for (int i = 0; i < MAX_MODIFIERS; i++) mods_q[i] <= '0;
		end else if (fire_s1) begin
			phase_q     <= phase_d;
			mod_count_q <= mod_count_d;
			used_q      <= used_d;
			err_q       <= err_d;
			mods_q      <= mods_d;
		end
	end

	// Result register: load on a producing beat, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, res_q.verdict_ok, res_q.bytes_used, res_q.conversion_char,
		res_q.mod_second, res_q.mod_first};
	assign m_tuser  = {res_q.is_final, res_q.has_token};

	`FSC_ASSERT_NOW(a_token_not_final, m_tvalid && m_tuser[0], !m_tuser[1], "token beat marked final")
	`FSC_ASSERT_NOW(a_token_bytes, m_tvalid && m_tuser[0], m_tdata[31:24] >= 8'd2, "token byte count below two")
	`FSC_ASSERT_NEXT(a_end_clears, fire_s1 && is_end_s1, used_q == 8'd0 && phase_q == fsc_pkg::PH_IDLE && !err_q, "terminator did not clear state")
	`FSC_ASSERT_NOW(a_mod_limit, 1'b1, mod_count_q <= CW'(MAX_MODIFIERS), "modifier count above limit")

endmodule
